[rtl/mspt_pkg.sv]
// Shared types and constants for the multi-slot period timer.
`default_nettype none

package mspt_pkg;

    localparam int CMD_W      = 3;
    localparam int SLOT_IDX_W = 4;
    localparam int NEW_PER_W  = 16;
    localparam int FIRED_W    = 8;
    localparam int TIME_W     = 32;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = FIRED_W + TIME_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_RELOAD = 3'd2,
        CMD_START  = 3'd3,
        CMD_STOP   = 3'd4
    } t_cmd;

    typedef struct packed {
        logic                  tick;
        logic                  add;
        logic                  reload;
        logic [SLOT_IDX_W-1:0] slot_index;
    } t_slot_ctrl;

endpackage

`default_nettype wire

[rtl/multi_slot_period_timer_top.sv]
// Top level of the multi-slot period timer: input register, control and result register.
`default_nettype none

// Multi-slot period timer. Each item carries a command (tick, add slot, reload,
// start, stop), a slot index and a period; each item gives exactly one result
// with the fired mask of slots that reached zero on that tick and the tick count
// after the item. One item is taken per clock cycle unless the result output is
// stalled; the item is first registered, and then all slot counters and the tick
// count update together while the result is registered.
// Slots at or beyond SLOT_COUNT are ignored; only slots 0 to 7 show in the mask.
module multi_slot_period_timer_top #(
    parameter int SLOT_COUNT  = 8,
    parameter int PERIOD_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [2:0] command, [6:3] slot_index, [22:7] new_period, [23] zero
    input  logic [mspt_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [7:0] fired_mask, [39:8] time_count
    output logic [mspt_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import mspt_pkg::*;

    logic                  r_in_valid;
    logic [CMD_W-1:0]      r_in_cmd;
    logic [SLOT_IDX_W-1:0] r_in_slot;
    logic [NEW_PER_W-1:0]  r_in_period;

    logic                  r_out_valid;
    logic [FIRED_W-1:0]    r_out_fired;
    logic [TIME_W-1:0]     r_out_time;

    logic                  r_ticking;
    logic                  n_ticking;
    logic [TIME_W-1:0]     r_tick_total;
    logic [TIME_W-1:0]     n_tick_total;

    logic                  w_in_take;
    logic                  w_advance;
    logic [PERIOD_BITS-1:0] w_period;
    t_slot_ctrl            w_ctrl;
    logic [FIRED_W-1:0]    w_fired;

    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    generate
        if (PERIOD_BITS > NEW_PER_W) begin : g_per_wide
            assign w_period = {{(PERIOD_BITS-NEW_PER_W){1'b0}}, r_in_period};
        end else if (PERIOD_BITS == NEW_PER_W) begin : g_per_same
            assign w_period = r_in_period;
        end else begin : g_per_narrow
            assign w_period = r_in_period[PERIOD_BITS-1:0];
        end
    endgenerate

    always_comb begin
        w_ctrl            = '0;
        w_ctrl.slot_index = r_in_slot;
        n_ticking         = r_ticking;
        n_tick_total      = r_tick_total;
        if (w_advance) begin
            case (t_cmd'(r_in_cmd))
                CMD_TICK: begin
                    if (r_ticking) begin
                        w_ctrl.tick  = 1'b1;
                        n_tick_total = r_tick_total + TIME_W'(1);
                    end
                end
                CMD_ADD:    w_ctrl.add    = 1'b1;
                CMD_RELOAD: w_ctrl.reload = 1'b1;
                CMD_START: begin
                    n_tick_total = '0;
                    n_ticking    = 1'b1;
                end
                CMD_STOP:   n_ticking = 1'b0;
                default: ;
            endcase
        end
    end

    mspt_slot_bank #(
        .SLOT_COUNT  (SLOT_COUNT),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_slot_bank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_period (w_period),
        .o_fired  (w_fired)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_ticking    <= 1'b0;
            r_tick_total <= '0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_ticking    <= n_ticking;
            r_tick_total <= n_tick_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_cmd    <= i_s_axis_tdata[CMD_W-1:0];
            r_in_slot   <= i_s_axis_tdata[CMD_W+SLOT_IDX_W-1:CMD_W];
            r_in_period <= i_s_axis_tdata[CMD_W+SLOT_IDX_W+NEW_PER_W-1:CMD_W+SLOT_IDX_W];
        end
        if (w_advance) begin
            r_out_fired <= w_fired;
            r_out_time  <= n_tick_total;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_time, r_out_fired};

endmodule

`default_nettype wire

[rtl/mspt_slot_bank.sv]
// Bank of slot countdown counters with active flags and fired detection.
`default_nettype none

module mspt_slot_bank #(
    parameter int SLOT_COUNT  = 8,
    parameter int PERIOD_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mspt_pkg::t_slot_ctrl       i_ctrl,
    input  logic [PERIOD_BITS-1:0]     i_period,
    output logic [mspt_pkg::FIRED_W-1:0] o_fired
);
    import mspt_pkg::*;

    logic [PERIOD_BITS-1:0] r_count [SLOT_COUNT];
    logic [PERIOD_BITS-1:0] n_count [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]  r_active;
    logic [SLOT_COUNT-1:0]  n_active;
    logic [SLOT_COUNT-1:0]  w_fire;

    genvar s;
    generate
        for (s = 0; s < SLOT_COUNT; s++) begin : g_slot
            logic w_hit;
            assign w_hit     = (i_ctrl.slot_index == SLOT_IDX_W'(s));
            assign w_fire[s] = i_ctrl.tick && r_active[s]
                               && (r_count[s] == PERIOD_BITS'(1));

            always_comb begin
                n_count[s]  = r_count[s];
                n_active[s] = r_active[s];
                if (i_ctrl.tick && r_active[s] && (r_count[s] != '0)) begin
                    n_count[s] = r_count[s] - PERIOD_BITS'(1);
                end else if (i_ctrl.add && w_hit) begin
                    n_active[s] = 1'b1;
                    n_count[s]  = i_period;
                end else if (i_ctrl.reload && w_hit && r_active[s]) begin
                    n_count[s] = i_period;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_count[s]  <= '0;
                    r_active[s] <= 1'b0;
                end else begin
                    r_count[s]  <= n_count[s];
                    r_active[s] <= n_active[s];
                end
            end
        end

        for (s = 0; s < FIRED_W; s++) begin : g_fired
            if (s < SLOT_COUNT) begin : g_shown
                assign o_fired[s] = w_fire[s];
            end else begin : g_absent
                assign o_fired[s] = 1'b0;
            end
        end
    endgenerate

endmodule

`default_nettype wire
